[design/mtpc_pkg.sv]
package mtpc_pkg;

	localparam int DataWidth = 32;
	localparam int AddrWidth = 32;
	localparam int WordWidth = 32;

	localparam int ModeWidth   = 2;
	localparam int KindWidth   = 2;
	localparam int StatusWidth = 3;
	localparam int ToggleWidth = 2;
	localparam int IndexWidth  = 2;
	localparam int CfgWidth    = 32;

	localparam logic [ModeWidth-1:0] MODE_START = 2'd0;
	localparam logic [ModeWidth-1:0] MODE_STEP  = 2'd1;
	localparam logic [ModeWidth-1:0] MODE_ABORT = 2'd2;

	localparam logic [KindWidth-1:0] KIND_WRITE = 2'd0;
	localparam logic [KindWidth-1:0] KIND_READ  = 2'd1;
	localparam logic [KindWidth-1:0] KIND_DONE  = 2'd2;

	localparam logic [StatusWidth-1:0] STATUS_RUN       = 3'd0;
	localparam logic [StatusWidth-1:0] STATUS_PASS      = 3'd1;
	localparam logic [StatusWidth-1:0] STATUS_WALK_FAIL = 3'd2;
	localparam logic [StatusWidth-1:0] STATUS_AIA_FAIL  = 3'd3;
	localparam logic [StatusWidth-1:0] STATUS_ABORT     = 3'd4;

	localparam logic [ToggleWidth-1:0] TOGGLE_BIT2 = 2'd1;
	localparam logic [ToggleWidth-1:0] TOGGLE_BIT3 = 2'd2;

	localparam logic [IndexWidth-1:0] REG_BASE   = 2'd0;
	localparam logic [IndexWidth-1:0] REG_LENGTH = 2'd1;
	localparam logic [IndexWidth-1:0] REG_TOGGLE = 2'd2;

	localparam logic [AddrWidth-1:0] WordStep = AddrWidth'(4);

endpackage

[design/mtpc_item_if.sv]
interface mtpc_item_if;
	logic                          valid;
	logic                          ready;
	logic [mtpc_pkg::ModeWidth-1:0] mode;
	logic [mtpc_pkg::WordWidth-1:0] read_data;

	modport source(output valid, mode, read_data, input ready);
	modport sink(input valid, mode, read_data, output ready);
endinterface

[design/mtpc_result_if.sv]
interface mtpc_result_if;
	logic                            valid;
	logic                            ready;
	logic [mtpc_pkg::KindWidth-1:0]   access_kind;
	logic [mtpc_pkg::AddrWidth-1:0]   address;
	logic [mtpc_pkg::WordWidth-1:0]   pattern;
	logic [mtpc_pkg::WordWidth-1:0]   observed;
	logic [mtpc_pkg::StatusWidth-1:0] status;

	modport source(output valid, access_kind, address, pattern, observed, status, input ready);
	modport sink(input valid, access_kind, address, pattern, observed, status, output ready);
endinterface

[design/memory_test_pattern_checker.sv]
// Memory test sequencer: a start word begins a test, and during a test every
// step word issues one memory access (write or read) or ends the test with a
// finished word carrying status, failing address, expected and observed data;
// an abort word ends the test as well. The test writes and reads back walking
// ones over DATA_WIDTH words from the base, then writes and reads back
// address-in-address over the configured length. The read data of a step word
// checks the read issued by the step before. The next access is formed by one
// address subtract and compare plus the data compare, straight into a single
// result register, so a word is accepted every cycle while that register is
// free or being drained. Configuration writes take effect at once.
module memory_test_pattern_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [mtpc_pkg::IndexWidth-1:0]     wr_index,
	input  logic [mtpc_pkg::CfgWidth-1:0]       wr_data,
	mtpc_item_if.sink                           item,
	mtpc_result_if.source                       result
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_WALK_WR,
		PH_WALK_RD,
		PH_AIA_WR,
		PH_AIA_RD
	} phase_t;

	logic [mtpc_pkg::AddrWidth-1:0]   base_q;
	logic [mtpc_pkg::AddrWidth-1:0]   len_q;
	logic [mtpc_pkg::ToggleWidth-1:0] toggle_q;

	phase_t                           phase_q, phase_d;
	logic [mtpc_pkg::AddrWidth-1:0]   addr_q, addr_d;
	logic [mtpc_pkg::DataWidth-1:0]   walk_q, walk_d;
	logic [mtpc_pkg::DataWidth-1:0]   expect_q, expect_d;
	logic                             pend_q, pend_d;

	logic                             res_valid_q;
	logic [mtpc_pkg::KindWidth-1:0]   res_kind_q;
	logic [mtpc_pkg::AddrWidth-1:0]   res_addr_q;
	logic [mtpc_pkg::WordWidth-1:0]   res_pat_q;
	logic [mtpc_pkg::WordWidth-1:0]   res_obs_q;
	logic [mtpc_pkg::StatusWidth-1:0] res_status_q;

	logic                             emit;
	logic [mtpc_pkg::KindWidth-1:0]   emit_kind;
	logic [mtpc_pkg::AddrWidth-1:0]   emit_addr;
	logic [mtpc_pkg::DataWidth-1:0]   emit_pat;
	logic [mtpc_pkg::DataWidth-1:0]   emit_obs;
	logic [mtpc_pkg::StatusWidth-1:0] emit_status;

	logic [mtpc_pkg::AddrWidth-1:0]   base_al;
	logic [mtpc_pkg::AddrWidth-1:0]   len_al;
	logic                             in_range;
	logic                             len_nz;
	logic [mtpc_pkg::DataWidth-1:0]   pat_addr;
	logic [mtpc_pkg::DataWidth-1:0]   pat_base;
	logic [mtpc_pkg::DataWidth-1:0]   rd;
	logic                             accept;

	function automatic logic [mtpc_pkg::DataWidth-1:0] aia_pattern(
		input logic [mtpc_pkg::AddrWidth-1:0]   a,
		input logic [mtpc_pkg::ToggleWidth-1:0] tm
	);
		logic inv;
		inv = ((tm == mtpc_pkg::TOGGLE_BIT2) && a[2]) ||
			((tm == mtpc_pkg::TOGGLE_BIT3) && a[3]);
		return inv ? ~mtpc_pkg::DataWidth'(a) : mtpc_pkg::DataWidth'(a);
	endfunction

	assign base_al  = {base_q[mtpc_pkg::AddrWidth-1:2], 2'b00};
	assign len_al   = {len_q[mtpc_pkg::AddrWidth-1:2], 2'b00};
	assign in_range = (addr_q - base_al) < len_al;
	assign len_nz   = len_al != '0;
	assign pat_addr = aia_pattern(addr_q, toggle_q);
	assign pat_base = aia_pattern(base_al, toggle_q);
	assign rd       = mtpc_pkg::DataWidth'(item.read_data);

	assign item.ready = !res_valid_q || result.ready;
	assign accept     = item.valid && item.ready;

	always_comb begin
		phase_d     = phase_q;
		addr_d      = addr_q;
		walk_d      = walk_q;
		expect_d    = expect_q;
		pend_d      = pend_q;
		emit        = 1'b0;
		emit_kind   = mtpc_pkg::KIND_DONE;
		emit_addr   = addr_q;
		emit_pat    = '0;
		emit_obs    = '0;
		emit_status = mtpc_pkg::STATUS_RUN;

		if (item.mode == mtpc_pkg::MODE_START) begin
			// first walking ones write at the base
			emit      = 1'b1;
			emit_kind = mtpc_pkg::KIND_WRITE;
			emit_addr = base_al;
			emit_pat  = mtpc_pkg::DataWidth'(1);
			phase_d   = PH_WALK_WR;
			addr_d    = base_al + mtpc_pkg::WordStep;
			walk_d    = mtpc_pkg::DataWidth'(2);
			expect_d  = '0;
			pend_d    = 1'b0;
		end else if (item.mode == mtpc_pkg::MODE_ABORT && phase_q != PH_IDLE) begin
			emit        = 1'b1;
			emit_status = mtpc_pkg::STATUS_ABORT;
			phase_d     = PH_IDLE;
			pend_d      = 1'b0;
			walk_d      = mtpc_pkg::DataWidth'(1);
		end else if (item.mode == mtpc_pkg::MODE_STEP && phase_q != PH_IDLE) begin
			emit   = 1'b1;
			pend_d = 1'b0;
			if (pend_q && rd != expect_q) begin
				emit_addr   = addr_q - mtpc_pkg::WordStep;
				emit_pat    = expect_q;
				emit_obs    = rd;
				emit_status = (phase_q == PH_WALK_RD) ? mtpc_pkg::STATUS_WALK_FAIL :
					mtpc_pkg::STATUS_AIA_FAIL;
				phase_d     = PH_IDLE;
				walk_d      = mtpc_pkg::DataWidth'(1);
			end else begin
				case (phase_q)
					PH_WALK_WR: begin
						if (walk_q != '0) begin
							emit_kind = mtpc_pkg::KIND_WRITE;
							emit_pat  = walk_q;
							walk_d    = walk_q << 1;
							addr_d    = addr_q + mtpc_pkg::WordStep;
						end else begin
							emit_kind = mtpc_pkg::KIND_READ;
							emit_addr = base_al;
							emit_pat  = mtpc_pkg::DataWidth'(1);
							expect_d  = mtpc_pkg::DataWidth'(1);
							pend_d    = 1'b1;
							phase_d   = PH_WALK_RD;
							walk_d    = mtpc_pkg::DataWidth'(2);
							addr_d    = base_al + mtpc_pkg::WordStep;
						end
					end
					PH_WALK_RD: begin
						if (walk_q != '0) begin
							emit_kind = mtpc_pkg::KIND_READ;
							emit_pat  = walk_q;
							expect_d  = walk_q;
							pend_d    = 1'b1;
							walk_d    = walk_q << 1;
							addr_d    = addr_q + mtpc_pkg::WordStep;
						end else begin
							walk_d = mtpc_pkg::DataWidth'(1);
							if (len_nz) begin
								emit_kind = mtpc_pkg::KIND_WRITE;
								emit_addr = base_al;
								emit_pat  = pat_base;
								phase_d   = PH_AIA_WR;
								addr_d    = base_al + mtpc_pkg::WordStep;
							end else begin
								emit_addr   = base_al + len_al;
								emit_status = mtpc_pkg::STATUS_PASS;
								phase_d     = PH_IDLE;
								addr_d      = '0;
							end
						end
					end
					PH_AIA_WR: begin
						if (in_range) begin
							emit_kind = mtpc_pkg::KIND_WRITE;
							emit_pat  = pat_addr;
							addr_d    = addr_q + mtpc_pkg::WordStep;
						end else if (len_nz) begin
							emit_kind = mtpc_pkg::KIND_READ;
							emit_addr = base_al;
							emit_pat  = pat_base;
							expect_d  = pat_base;
							pend_d    = 1'b1;
							phase_d   = PH_AIA_RD;
							addr_d    = base_al + mtpc_pkg::WordStep;
						end else begin
							emit_addr   = base_al + len_al;
							emit_status = mtpc_pkg::STATUS_PASS;
							phase_d     = PH_IDLE;
							addr_d      = '0;
						end
					end
					PH_AIA_RD: begin
						if (in_range) begin
							emit_kind = mtpc_pkg::KIND_READ;
							emit_pat  = pat_addr;
							expect_d  = pat_addr;
							pend_d    = 1'b1;
							addr_d    = addr_q + mtpc_pkg::WordStep;
						end else begin
							emit_addr   = base_al + len_al;
							emit_status = mtpc_pkg::STATUS_PASS;
							phase_d     = PH_IDLE;
							addr_d      = '0;
						end
					end
					default: begin
						emit = 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			len_q    <= '0;
			toggle_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				mtpc_pkg::REG_BASE:   base_q   <= mtpc_pkg::AddrWidth'(wr_data);
				mtpc_pkg::REG_LENGTH: len_q    <= mtpc_pkg::AddrWidth'(wr_data);
				mtpc_pkg::REG_TOGGLE: toggle_q <= wr_data[mtpc_pkg::ToggleWidth-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			addr_q   <= '0;
			walk_q   <= mtpc_pkg::DataWidth'(1);
			expect_q <= '0;
			pend_q   <= 1'b0;
		end else if (accept) begin
			phase_q  <= phase_d;
			addr_q   <= addr_d;
			walk_q   <= walk_d;
			expect_q <= expect_d;
			pend_q   <= pend_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= emit;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			res_kind_q   <= emit_kind;
			res_addr_q   <= emit_addr;
			res_pat_q    <= mtpc_pkg::WordWidth'(emit_pat);
			res_obs_q    <= mtpc_pkg::WordWidth'(emit_obs);
			res_status_q <= emit_status;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.access_kind = res_kind_q;
	assign result.address     = res_addr_q;
	assign result.pattern     = res_pat_q;
	assign result.observed    = res_obs_q;
	assign result.status      = res_status_q;

endmodule
